// File: src/timed_segment_velocity_mapper_macros.svh
// assertion macros for the timed segment velocity mapper
`ifndef TIMED_SEGMENT_VELOCITY_MAPPER_MACROS_SVH
`define TIMED_SEGMENT_VELOCITY_MAPPER_MACROS_SVH
`ifndef SYNTHESIS
`define TSVM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TSVM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TSVM_ASSERT(lbl, clk, rst_n, prop, msg)
`define TSVM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: src/tsvm_pkg.sv
// shared types, constants and level mapping functions of the segment velocity mapper
package tsvm_pkg;

	localparam int SEGMENT_DEPTH_DEF = 64;
	localparam int TIME_W = 32;
	localparam int LVL_W  = 2;
	localparam int INST_W = 8;
	localparam int VEL_W  = 8;
	localparam int TYPE_W = 2;

	typedef enum logic [TYPE_W-1:0] {
		REQ_LOAD    = 2'd0,
		REQ_EVENT   = 2'd1,
		REQ_RESTART = 2'd2
	} req_kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_INS_WR,
		ST_FND_RD,
		ST_FND_CMP,
		ST_PRV_CMP,
		ST_LST_CMP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [TIME_W-1:0] start_time;
		logic [TIME_W-1:0] end_time;
		logic [LVL_W-1:0]  drum;
		logic [LVL_W-1:0]  cymbal;
	} seg_entry_t;

	typedef struct packed {
		logic start_lt;
		logic start_eq;
		logic end_gt;
	} cmp_flags_t;

	localparam logic [INST_W-1:0] INST_SILENT  = INST_W'(0);
	localparam logic [INST_W-1:0] INST_DRUM_LO = INST_W'(1);
	localparam logic [INST_W-1:0] INST_DRUM_HI = INST_W'(4);
	localparam logic [INST_W-1:0] INST_CYM_LO  = INST_W'(5);
	localparam logic [INST_W-1:0] INST_CYM_HI  = INST_W'(8);

	localparam logic [LVL_W-1:0] LVL_ONE = LVL_W'(1);
	localparam logic [LVL_W-1:0] LVL_TWO = LVL_W'(2);

	localparam logic [VEL_W-1:0] VEL_LOW  = VEL_W'(3);
	localparam logic [VEL_W-1:0] VEL_MID  = VEL_W'(5);
	localparam logic [VEL_W-1:0] VEL_HIGH = VEL_W'(7);

	function automatic logic [VEL_W-1:0] map_level(input logic [LVL_W-1:0] lvl,
		input logic en);
		logic [VEL_W-1:0] v;
		if (!en) begin
			v = VEL_W'(lvl);
		end else if (lvl <= LVL_ONE) begin
			v = VEL_LOW;
		end else if (lvl == LVL_TWO) begin
			v = VEL_MID;
		end else begin
			v = VEL_HIGH;
		end
		return v;
	endfunction

	function automatic logic [VEL_W-1:0] pick(input logic [INST_W-1:0] inst,
		input seg_entry_t seg, input logic [VEL_W-1:0] oldv, input logic en);
		logic [LVL_W-1:0] lvl;
		logic [VEL_W-1:0] v;
		lvl = '0;
		if (inst >= INST_DRUM_LO && inst <= INST_DRUM_HI) begin
			lvl = seg.drum;
		end else if (inst >= INST_CYM_LO && inst <= INST_CYM_HI) begin
			lvl = seg.cymbal;
		end
		if (inst == INST_SILENT) begin
			v = oldv;
		end else begin
			v = map_level(lvl, en);
		end
		return v;
	endfunction

endpackage

// File: src/tsvm_req_if.sv
// request channel: segment loads, note events and restarts
interface tsvm_req_if;
	import tsvm_pkg::*;
	logic                valid;
	logic                ready;
	logic [TYPE_W-1:0]   req_type;
	logic [TIME_W-1:0]   seg_start;
	logic [TIME_W-1:0]   seg_end;
	logic [LVL_W-1:0]    seg_drum_level;
	logic [LVL_W-1:0]    seg_cymbal_level;
	logic [TIME_W-1:0]   delta_time;
	logic [INST_W-1:0]   right_instrument;
	logic [INST_W-1:0]   left_instrument;
	logic [VEL_W-1:0]    right_velocity_in;
	logic [VEL_W-1:0]    left_velocity_in;

	modport source (
		output valid, req_type, seg_start, seg_end, seg_drum_level, seg_cymbal_level,
			delta_time, right_instrument, left_instrument, right_velocity_in,
			left_velocity_in,
		input  ready
	);
	modport sink (
		input  valid, req_type, seg_start, seg_end, seg_drum_level, seg_cymbal_level,
			delta_time, right_instrument, left_instrument, right_velocity_in,
			left_velocity_in,
		output ready
	);
endinterface

// File: src/tsvm_rsp_if.sv
// result channel: mapped velocities and status
interface tsvm_rsp_if;
	import tsvm_pkg::*;
	logic               valid;
	logic               ready;
	logic [VEL_W-1:0]   right_velocity_out;
	logic [VEL_W-1:0]   left_velocity_out;
	logic               segment_found;
	logic               status;

	modport source (
		output valid, right_velocity_out, left_velocity_out, segment_found, status,
		input  ready
	);
	modport sink (
		input  valid, right_velocity_out, left_velocity_out, segment_found, status,
		output ready
	);
endinterface

// File: src/tsvm_cfg_if.sv
// configuration write channel carrying the mapping enable
interface tsvm_cfg_if;
	logic valid;
	logic ready;
	logic map_enable;

	modport source (
		output valid, map_enable,
		input  ready
	);
	modport sink (
		input  valid, map_enable,
		output ready
	);
endinterface

// File: src/timed_segment_velocity_mapper.sv
// top level: segment table, insert and cursor search sequencer, result register
//
//   channel  dir  carries
//   req      in   load / note event / restart request
//   rsp      out  mapped velocities, segment_found, status
//   cfg      in   map_enable write
//
// a load reads and shifts each stored segment it moves past, then writes the new one
// a note event reads and compares one segment per cursor step; restart only clears state
// each result waits in the done state while the previous result stalls on rsp
// the pace is set by the one read port of the segment ram and the shared compare unit
// after reset the table is empty and map_enable is 1; no clearing pass
// a new request is taken while the previous result still waits on rsp
`include "timed_segment_velocity_mapper_macros.svh"
module timed_segment_velocity_mapper #(
	parameter int SEGMENT_DEPTH = tsvm_pkg::SEGMENT_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	tsvm_req_if.sink      req,
	tsvm_rsp_if.source    rsp,
	tsvm_cfg_if.sink      cfg
);
	import tsvm_pkg::*;

	localparam int IDX_W = (SEGMENT_DEPTH > 1) ? $clog2(SEGMENT_DEPTH) : 1;
	localparam int CNT_W = $clog2(SEGMENT_DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SEGMENT_DEPTH);

	state_t state_q, state_d;

	logic [CNT_W-1:0]  cnt_q, cur_q, pos_q;
	logic [CNT_W-1:0]  pos_m1, cur_m1, cnt_m1;
	logic [TIME_W-1:0] time_q;
	logic [TIME_W:0]   time_sum;
	logic              map_en_q;

	seg_entry_t        new_q;
	logic [INST_W-1:0] rin_q, lin_q;
	logic [VEL_W-1:0]  rv_q, lv_q;
	logic [VEL_W-1:0]  res_rv_q, res_lv_q;
	logic              res_found_q, res_status_q;

	logic              out_valid_q;
	logic [VEL_W-1:0]  out_rv_q, out_lv_q;
	logic              out_found_q, out_status_q;

	logic              ram_we, ram_re;
	logic [IDX_W-1:0]  ram_waddr, ram_raddr;
	seg_entry_t        ram_wdata, ram_rdata;
	seg_entry_t        req_entry;

	logic [TIME_W-1:0] key_lo, key_hi;
	cmp_flags_t        flags;
	logic              stored_gt, t_lt_start, holds;

	logic              req_acc, found_hit, cur_inc, pos_dec, cnt_inc, load_out;

	assign pos_m1   = pos_q - 1'b1;
	assign cur_m1   = cur_q - 1'b1;
	assign cnt_m1   = cnt_q - 1'b1;
	assign time_sum = {1'b0, time_q} + {1'b0, req.delta_time};

	assign req_entry = '{start_time: req.seg_start, end_time: req.seg_end,
		drum: req.seg_drum_level, cymbal: req.seg_cymbal_level};

	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	assign rsp.valid              = out_valid_q;
	assign rsp.right_velocity_out = out_rv_q;
	assign rsp.left_velocity_out  = out_lv_q;
	assign rsp.segment_found      = out_found_q;
	assign rsp.status             = out_status_q;

	tsvm_ram #(
		.WIDTH ($bits(seg_entry_t)),
		.DEPTH (SEGMENT_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign key_lo = (state_q == ST_INS_CMP) ? new_q.start_time : time_q;
	assign key_hi = (state_q == ST_INS_CMP) ? new_q.end_time : time_q;

	tsvm_cmp u_cmp (
		.key_lo (key_lo),
		.key_hi (key_hi),
		.entry  (ram_rdata),
		.flags  (flags)
	);

	assign stored_gt  = (!flags.start_lt && !flags.start_eq) ||
		(flags.start_eq && flags.end_gt);
	assign t_lt_start = !flags.start_lt && !flags.start_eq;
	assign holds      = (flags.start_lt || flags.start_eq) && flags.end_gt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = pos_q[IDX_W-1:0];
		ram_wdata = new_q;
		ram_re    = 1'b0;
		ram_raddr = cur_q[IDX_W-1:0];
		found_hit = 1'b0;
		cur_inc   = 1'b0;
		pos_dec   = 1'b0;
		cnt_inc   = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					case (req.req_type)
						REQ_LOAD: begin
							if (cnt_q == CNT_FULL) begin
								state_d = ST_DONE;
							end else if (cnt_q == '0) begin
								ram_we    = 1'b1;
								ram_waddr = '0;
								ram_wdata = req_entry;
								cnt_inc   = 1'b1;
								state_d   = ST_DONE;
							end else begin
								state_d = ST_INS_RD;
							end
						end
						REQ_EVENT: state_d = ST_FND_RD;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_INS_RD: begin
				ram_re    = 1'b1;
				ram_raddr = pos_m1[IDX_W-1:0];
				state_d   = ST_INS_CMP;
			end
			ST_INS_CMP: begin
				ram_we = 1'b1;
				if (stored_gt) begin
					ram_wdata = ram_rdata;
					pos_dec   = 1'b1;
					state_d   = (pos_m1 == '0) ? ST_INS_WR : ST_INS_RD;
				end else begin
					cnt_inc = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_INS_WR: begin
				ram_we  = 1'b1;
				cnt_inc = 1'b1;
				state_d = ST_DONE;
			end
			ST_FND_RD: begin
				if (cur_q < cnt_q) begin
					ram_re  = 1'b1;
					state_d = ST_FND_CMP;
				end else if (cnt_q != '0) begin
					ram_re    = 1'b1;
					ram_raddr = cnt_m1[IDX_W-1:0];
					state_d   = ST_LST_CMP;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_FND_CMP: begin
				if (t_lt_start) begin
					if (cur_q == '0) begin
						state_d = ST_DONE;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = cur_m1[IDX_W-1:0];
						state_d   = ST_PRV_CMP;
					end
				end else if (holds) begin
					found_hit = 1'b1;
					state_d   = ST_DONE;
				end else begin
					cur_inc = 1'b1;
					state_d = ST_FND_RD;
				end
			end
			ST_PRV_CMP, ST_LST_CMP: begin
				found_hit = holds;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			cur_q       <= '0;
			time_q      <= '0;
			map_en_q    <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				map_en_q <= cfg.map_enable;
			end
			if (req_acc && req.req_type == REQ_EVENT) begin
				time_q <= time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];
			end
			if (req_acc && req.req_type == REQ_RESTART) begin
				cnt_q  <= '0;
				cur_q  <= '0;
				time_q <= '0;
			end
			if (cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cur_inc) begin
				cur_q <= cur_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			new_q        <= req_entry;
			rin_q        <= req.right_instrument;
			lin_q        <= req.left_instrument;
			rv_q         <= req.right_velocity_in;
			lv_q         <= req.left_velocity_in;
			pos_q        <= cnt_q;
			res_rv_q     <= (req.req_type == REQ_EVENT) ? req.right_velocity_in : '0;
			res_lv_q     <= (req.req_type == REQ_EVENT) ? req.left_velocity_in : '0;
			res_found_q  <= 1'b0;
			res_status_q <= (req.req_type == REQ_LOAD) && (cnt_q == CNT_FULL);
		end
		if (pos_dec) begin
			pos_q <= pos_m1;
		end
		if (found_hit) begin
			res_rv_q    <= pick(rin_q, ram_rdata, rv_q, map_en_q);
			res_lv_q    <= pick(lin_q, ram_rdata, lv_q, map_en_q);
			res_found_q <= 1'b1;
		end
		if (load_out) begin
			out_rv_q     <= res_rv_q;
			out_lv_q     <= res_lv_q;
			out_found_q  <= res_found_q;
			out_status_q <= res_status_q;
		end
	end

	`TSVM_ASSERT(a_cnt_bound, clk, arst_n, (cnt_q <= CNT_FULL), "segment count above depth")
	`TSVM_ASSERT(a_cur_bound, clk, arst_n, (cur_q <= cnt_q), "cursor past segment count")
	`TSVM_ASSERT(a_ins_pos, clk, arst_n,
		((state_q == ST_INS_CMP) |-> (pos_q != '0)), "insert slot zero in compare")
	`TSVM_ASSERT(a_we_states, clk, arst_n,
		(ram_we |-> (state_q == ST_IDLE || state_q == ST_INS_CMP || state_q == ST_INS_WR)),
		"ram write outside insert")
	`TSVM_ASSERT(a_done_out, clk, arst_n,
		((state_q == ST_DONE && (!out_valid_q || rsp.ready)) |=> rsp.valid),
		"finished request not shown")
endmodule

// File: src/tsvm_ram.sv
// generic single write port, single read port ram with registered read data
module tsvm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [$clog2(DEPTH)-1:0]          waddr,
	input  logic [WIDTH-1:0]                  wdata,
	input  logic                              re,
	input  logic [$clog2(DEPTH)-1:0]          raddr,
	output logic [WIDTH-1:0]                  rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// File: src/tsvm_cmp.sv
// shared key compare unit against one stored segment
module tsvm_cmp (
	input  logic [tsvm_pkg::TIME_W-1:0] key_lo,
	input  logic [tsvm_pkg::TIME_W-1:0] key_hi,
	input  tsvm_pkg::seg_entry_t        entry,
	output tsvm_pkg::cmp_flags_t        flags
);
	import tsvm_pkg::*;

	always_comb begin
		flags.start_lt = entry.start_time < key_lo;
		flags.start_eq = entry.start_time == key_lo;
		flags.end_gt   = entry.end_time > key_hi;
	end
endmodule

// File: tb/tsvm_velocity_checker.sv
// checker for the segment velocity mapper: predicts every result and compares it on rsp
module tsvm_velocity_checker (
	input  logic clk,
	input  logic arst_n,
	tsvm_req_if  req,
	tsvm_rsp_if  rsp,
	tsvm_cfg_if  cfg,
	output int   mismatches,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import tsvm_pkg::*;

	localparam int DEPTH = SEGMENT_DEPTH_DEF;
	localparam int PRINT_CAP = 100;

	typedef struct packed {
		logic [VEL_W-1:0] right_vel;
		logic [VEL_W-1:0] left_vel;
		logic             found;
		logic             dropped;
	} velocity_result_t;

	logic [TIME_W-1:0] seg_starts [DEPTH];
	logic [TIME_W-1:0] seg_ends [DEPTH];
	logic [LVL_W-1:0]  seg_drums [DEPTH];
	logic [LVL_W-1:0]  seg_cymbals [DEPTH];
	int unsigned       seg_count;
	int unsigned       cursor;
	logic [TIME_W-1:0] now_time;
	logic              map_en;
	velocity_result_t  expected_q [$];

	initial mismatches = 0;

	task automatic report_mismatch(input string what);
		if (mismatches < PRINT_CAP) begin
			$display("[%0t] mismatch: %s", $time, what);
		end
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [VEL_W-1:0] got,
		input logic [VEL_W-1:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
		end
	endtask

	function automatic logic holds_time(input int unsigned idx, input logic [TIME_W-1:0] t);
		return t >= seg_starts[idx] && t < seg_ends[idx];
	endfunction

	// forward-only walk, falls back to the segment just behind the cursor or to the last segment
	function automatic int locate_segment(input logic [TIME_W-1:0] t);
		while (cursor < seg_count) begin
			if (t < seg_starts[cursor]) begin
				if (cursor == 0) begin
					return -1;
				end
				return holds_time(cursor - 1, t) ? int'(cursor - 1) : -1;
			end
			if (holds_time(cursor, t)) begin
				return int'(cursor);
			end
			cursor++;
		end
		if (seg_count > 0 && holds_time(seg_count - 1, t)) begin
			return int'(seg_count - 1);
		end
		return -1;
	endfunction

	function automatic logic store_segment(input logic [TIME_W-1:0] s,
		input logic [TIME_W-1:0] e, input logic [LVL_W-1:0] d, input logic [LVL_W-1:0] c);
		int unsigned pos;
		if (seg_count >= DEPTH) begin
			return 1'b0;
		end
		pos = seg_count;
		while (pos > 0 && (seg_starts[pos-1] > s ||
			(seg_starts[pos-1] == s && seg_ends[pos-1] > e))) begin
			seg_starts[pos]  = seg_starts[pos-1];
			seg_ends[pos]    = seg_ends[pos-1];
			seg_drums[pos]   = seg_drums[pos-1];
			seg_cymbals[pos] = seg_cymbals[pos-1];
			pos--;
		end
		seg_starts[pos]  = s;
		seg_ends[pos]    = e;
		seg_drums[pos]   = d;
		seg_cymbals[pos] = c;
		seg_count++;
		return 1'b1;
	endfunction

	function automatic logic [VEL_W-1:0] level_velocity(input logic [LVL_W-1:0] lvl);
		if (!map_en) begin
			return VEL_W'(lvl);
		end
		if (lvl <= LVL_ONE) begin
			return VEL_LOW;
		end
		if (lvl == LVL_TWO) begin
			return VEL_MID;
		end
		return VEL_HIGH;
	endfunction

	function automatic logic [VEL_W-1:0] hand_velocity(input int idx,
		input logic [INST_W-1:0] inst, input logic [VEL_W-1:0] oldv);
		if (inst == INST_SILENT) begin
			return oldv;
		end
		if (inst >= INST_DRUM_LO && inst <= INST_DRUM_HI) begin
			return level_velocity(seg_drums[idx]);
		end
		if (inst >= INST_CYM_LO && inst <= INST_CYM_HI) begin
			return level_velocity(seg_cymbals[idx]);
		end
		return level_velocity(LVL_W'(0));
	endfunction

	function automatic velocity_result_t predict_result();
		velocity_result_t res;
		logic [TIME_W:0]  sum;
		int               idx;
		res = '0;
		case (req.req_type)
			REQ_LOAD: begin
				res.dropped = !store_segment(req.seg_start, req.seg_end, req.seg_drum_level,
					req.seg_cymbal_level);
			end
			REQ_EVENT: begin
				sum = {1'b0, now_time} + {1'b0, req.delta_time};
				now_time = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
				idx = locate_segment(now_time);
				res.right_vel = req.right_velocity_in;
				res.left_vel = req.left_velocity_in;
				if (idx >= 0) begin
					res.right_vel = hand_velocity(idx, req.right_instrument,
						req.right_velocity_in);
					res.left_vel = hand_velocity(idx, req.left_instrument,
						req.left_velocity_in);
					res.found = 1'b1;
				end
			end
			REQ_RESTART: begin
				seg_count = 0;
				cursor = 0;
				now_time = '0;
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		velocity_result_t want;
		if (!arst_n) begin
			seg_count = 0;
			cursor = 0;
			now_time = '0;
			map_en = 1'b1;
			expected_q.delete();
			pending = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("result with no request outstanding");
				end else begin
					want = expected_q.pop_front();
					check_field("right_velocity_out", rsp.right_velocity_out, want.right_vel);
					check_field("left_velocity_out", rsp.left_velocity_out, want.left_vel);
					check_field("segment_found", VEL_W'(rsp.segment_found), VEL_W'(want.found));
					check_field("status", VEL_W'(rsp.status), VEL_W'(want.dropped));
				end
			end
			if (cfg.valid && cfg.ready) begin
				map_en = cfg.map_enable;
			end
			if (req.valid && req.ready) begin
				expected_q.insert(expected_q.size(), predict_result());
			end
			pending = expected_q.size();
		end
	end

endmodule

// File: tb/tb_timed_segment_velocity_mapper.sv
// testbench top for the segment velocity mapper: clock, reset, request stimulus and verdict
module tb_timed_segment_velocity_mapper;
	timeunit 1ns;
	timeprecision 1ps;
	import tsvm_pkg::*;

	localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 160;
	localparam int PHASE_COUNT  = 8;
	localparam int PHASE_ITEMS  = 64;
	localparam int MAX_GAP      = 40;

	typedef struct {
		logic [TYPE_W-1:0] kind;
		logic [TIME_W-1:0] start_t;
		logic [TIME_W-1:0] end_t;
		logic [LVL_W-1:0]  drum;
		logic [LVL_W-1:0]  cymbal;
		logic [TIME_W-1:0] delta;
		logic [INST_W-1:0] right_inst;
		logic [INST_W-1:0] left_inst;
		logic [VEL_W-1:0]  right_vel;
		logic [VEL_W-1:0]  left_vel;
	} request_t;

	logic              clk;
	logic              arst_n;
	int                mismatches;
	int                pending;
	int                cycle_count = 0;
	int                items_sent = 0;
	int                send_idle_pct = 0;
	int                stall_pct = 0;
	logic [TIME_W-1:0] last_start = '0;
	logic [TIME_W-1:0] last_end = '0;

	tsvm_req_if req_ch ();
	tsvm_rsp_if rsp_ch ();
	tsvm_cfg_if cfg_ch ();

	timed_segment_velocity_mapper i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	tsvm_velocity_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.cfg        (cfg_ch),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic request_t random_request();
		request_t r;
		r.kind       = REQ_LOAD;
		r.start_t    = $urandom();
		r.end_t      = $urandom();
		r.drum       = LVL_W'($urandom_range(3));
		r.cymbal     = LVL_W'($urandom_range(3));
		r.delta      = $urandom();
		r.right_inst = INST_W'($urandom_range(255));
		r.left_inst  = INST_W'($urandom_range(255));
		r.right_vel  = VEL_W'($urandom_range(255));
		r.left_vel   = VEL_W'($urandom_range(255));
		return r;
	endfunction

	function automatic request_t load_req(input logic [TIME_W-1:0] s, input logic [TIME_W-1:0] e,
		input logic [LVL_W-1:0] d, input logic [LVL_W-1:0] c);
		request_t r;
		r = random_request();
		r.kind    = REQ_LOAD;
		r.start_t = s;
		r.end_t   = e;
		r.drum    = d;
		r.cymbal  = c;
		return r;
	endfunction

	function automatic request_t note_req(input logic [TIME_W-1:0] dt,
		input logic [INST_W-1:0] ri, input logic [INST_W-1:0] li,
		input logic [VEL_W-1:0] rv, input logic [VEL_W-1:0] lv);
		request_t r;
		r = random_request();
		r.kind       = REQ_EVENT;
		r.delta      = dt;
		r.right_inst = ri;
		r.left_inst  = li;
		r.right_vel  = rv;
		r.left_vel   = lv;
		return r;
	endfunction

	function automatic request_t plain_req(input logic [TYPE_W-1:0] kind);
		request_t r;
		r = random_request();
		r.kind = kind;
		return r;
	endfunction

	function automatic logic [INST_W-1:0] random_instrument();
		if ($urandom_range(7) == 0) begin
			return INST_W'($urandom_range(255));
		end
		return INST_W'($urandom_range(8));
	endfunction

	task automatic send_request(input request_t r);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) begin
			gap++;
		end
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid             <= 1'b1;
		req_ch.req_type          <= r.kind;
		req_ch.seg_start         <= r.start_t;
		req_ch.seg_end           <= r.end_t;
		req_ch.seg_drum_level    <= r.drum;
		req_ch.seg_cymbal_level  <= r.cymbal;
		req_ch.delta_time        <= r.delta;
		req_ch.right_instrument  <= r.right_inst;
		req_ch.left_instrument   <= r.left_inst;
		req_ch.right_velocity_in <= r.right_vel;
		req_ch.left_velocity_in  <= r.left_vel;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
	endtask

	task automatic write_map_enable(input logic en);
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		cfg_ch.valid      <= 1'b1;
		cfg_ch.map_enable <= en;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic send_random_load(input logic [TIME_W-1:0] span);
		logic [TIME_W-1:0] s;
		logic [TIME_W:0]   e;
		case ($urandom_range(15))
			0: begin
				s = last_start;
				e = {1'b0, last_end};
			end
			1: begin
				s = $urandom();
				e = {1'b0, $urandom()};
			end
			2: begin
				s = $urandom_range(span);
				e = {1'b0, s};
			end
			3: begin
				s = $urandom_range(span);
				e = {1'b0, s - $urandom_range(s)};
			end
			default: begin
				s = $urandom_range(span);
				e = {1'b0, s} + $urandom_range((span >> 3) + 1, 1);
				if (e[TIME_W]) begin
					e = {1'b0, {TIME_W{1'b1}}};
				end
			end
		endcase
		last_start = s;
		last_end = e[TIME_W-1:0];
		send_request(load_req(s, e[TIME_W-1:0], LVL_W'($urandom_range(3)),
			LVL_W'($urandom_range(3))));
	endtask

	// optional restart, loads spread over a time span, then notes that walk through that span
	task automatic run_sequence(input int n_loads, input int n_notes);
		int                i;
		int                span_bits;
		logic [TIME_W-1:0] span;
		logic [TIME_W-1:0] note_step;
		logic [TIME_W-1:0] dt;
		span_bits = $urandom_range(31, 4);
		span = {TIME_W{1'b1}} >> (TIME_W - span_bits);
		note_step = span / (n_notes + 1);
		if ($urandom_range(9) != 0) begin
			send_request(plain_req(REQ_RESTART));
		end
		for (i = 0; i < n_loads; i++) begin
			send_random_load(span);
		end
		for (i = 0; i < n_notes; i++) begin
			case ($urandom_range(59))
				0: send_request(plain_req(REQ_UNUSED));
				1, 2, 3, 4: send_random_load(span);
				default: begin
				end
			endcase
			case ($urandom_range(19))
				0: dt = '0;
				1: dt = $urandom();
				default: dt = $urandom_range(2 * note_step);
			endcase
			send_request(note_req(dt, random_instrument(), random_instrument(),
				VEL_W'($urandom_range(255)), VEL_W'($urandom_range(255))));
		end
	endtask

	initial begin
		int phase;
		int goal;
		logic first;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_LOAD;
		req_ch.seg_start = '0;
		req_ch.seg_end = '0;
		req_ch.seg_drum_level = '0;
		req_ch.seg_cymbal_level = '0;
		req_ch.delta_time = '0;
		req_ch.right_instrument = '0;
		req_ch.left_instrument = '0;
		req_ch.right_velocity_in = '0;
		req_ch.left_velocity_in = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.map_enable = 1'b1;
		rsp_ch.ready = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// empty table, unused type, ordered inserts with equal keys and empty segments
		send_request(note_req(32'h0000_0000, INST_DRUM_LO, INST_CYM_LO, 8'hFF, 8'h00));
		send_request(plain_req(REQ_UNUSED));
		send_request(load_req(32'h0001_0000, 32'h0002_0000, 2'd3, 2'd2));
		send_request(load_req(32'h0001_0000, 32'h0001_8000, 2'd1, 2'd0));
		send_request(load_req(32'h0001_0000, 32'h0002_0000, 2'd0, 2'd1));
		send_request(load_req(32'h0003_0000, 32'h0003_0000, 2'd3, 2'd3));
		send_request(load_req(32'h0003_0000, 32'h0002_FFFF, 2'd3, 2'd3));
		send_request(load_req(32'h0000_0000, 32'h0000_8000, 2'd2, 2'd3));
		// cursor walk, silent hand, drum, cymbal and other codes
		send_request(note_req(32'h0000_4000, INST_SILENT, INST_DRUM_LO, 8'hAA, 8'h55));
		send_request(note_req(32'h0000_C000, INST_CYM_LO, 8'd9, 8'h12, 8'h34));
		send_request(note_req(32'h0000_8000, INST_DRUM_HI, INST_CYM_HI, 8'h80, 8'h01));
		send_request(load_req(32'h0002_0000, 32'h0002_8000, 2'd2, 2'd1));
		send_request(note_req(32'h0000_8000, 8'hFF, 8'd2, 8'h7F, 8'hFE));
		send_request(note_req(32'h0001_0000, 8'd3, 8'd6, 8'h11, 8'h22));
		// saturation of the running time
		send_request(load_req(32'hFFFF_0000, 32'hFFFF_FFFF, 2'd1, 2'd2));
		send_request(note_req(32'hFFFF_FFFF, INST_CYM_HI, INST_DRUM_LO, 8'h00, 8'hFF));
		send_request(note_req(32'hFFFF_FFFF, 8'd7, INST_SILENT, 8'h33, 8'h44));
		send_request(plain_req(REQ_RESTART));
		send_request(note_req(32'h0000_0005, INST_DRUM_LO, INST_CYM_LO, 8'h66, 8'h77));
		send_request(load_req(32'h0000_0000, 32'hFFFF_FFFF, 2'd0, 2'd3));
		send_request(note_req(32'h0000_0001, 8'd2, INST_CYM_HI, 8'h01, 8'h02));

		for (phase = 0; phase < PHASE_COUNT; phase++) begin
			case (phase % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 67;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 67;
				end
				default: begin
					send_idle_pct = 13;
					stall_pct = 13;
				end
			endcase
			write_map_enable(((phase % 2) ^ (phase / 4)) != 0);
			goal = items_sent + PHASE_ITEMS;
			first = 1'b1;
			while (items_sent < goal) begin
				// overfill the table once per map setting
				if (first && phase % 4 == 1) begin
					run_sequence(SEGMENT_DEPTH_DEF + 2, $urandom_range(40, 10));
				end else begin
					run_sequence($urandom_range(12), $urandom_range(25, 1));
				end
				first = 1'b0;
			end
		end

		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+src
src/tsvm_pkg.sv
src/tsvm_req_if.sv
src/tsvm_rsp_if.sv
src/tsvm_cfg_if.sv
src/tsvm_ram.sv
src/tsvm_cmp.sv
src/timed_segment_velocity_mapper.sv
tb/tsvm_velocity_checker.sv
tb/tb_timed_segment_velocity_mapper.sv
